@@ rtl/isu_pkg.sv @@
// Shared types and constants for the indexed sequence store unit.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package isu_pkg;

   localparam int DEPTH          = 16;
   localparam int VALUE_WIDTH    = 32;
   localparam int MODE_WIDTH     = 3;
   localparam int POS_WIDTH      = 5;
   localparam int SHIFT_WIDTH    = 5;
   localparam int STATUS_WIDTH   = 2;
   localparam int FOUND_WIDTH    = 4;
   localparam int COUNT_OUT_WIDTH = 5;
   localparam int INDEX_WIDTH    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH    = $clog2(DEPTH + 1);
   localparam int CMP_WIDTH      = (COUNT_WIDTH > POS_WIDTH) ? COUNT_WIDTH : POS_WIDTH;

   localparam int REQ_BITS  = MODE_WIDTH + POS_WIDTH + VALUE_WIDTH + SHIFT_WIDTH;
   localparam int REQ_WIDTH = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS  = STATUS_WIDTH + VALUE_WIDTH + FOUND_WIDTH + COUNT_OUT_WIDTH;
   localparam int RSP_WIDTH = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_INSERT = 3'd0,
      MODE_REMOVE = 3'd1,
      MODE_READ   = 3'd2,
      MODE_FIND   = 3'd3,
      MODE_ROTATE = 3'd4,
      MODE_CLEAR  = 3'd5
   } mode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_NONE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type                   op;
      logic [CMP_WIDTH-1:0]          pos;
      logic [CMP_WIDTH-1:0]          count;
      logic signed [VALUE_WIDTH-1:0] key;
   } cell_cmd_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_ROTATE = 1'b1
   } state_type;

endpackage

`default_nettype wire

@@ rtl/isu_cell.sv @@
// One storage cell of the sequence chain: holds a value, takes a neighbor's value or the key on command.
// Depends on isu_pkg.
`default_nettype none

module isu_cell (
   input  wire logic                                   clock,
   input  wire logic [isu_pkg::CMP_WIDTH-1:0]          cell_index,
   input  wire isu_pkg::cell_cmd_type                   cmd,
   input  wire logic signed [isu_pkg::VALUE_WIDTH-1:0] left_value,
   input  wire logic signed [isu_pkg::VALUE_WIDTH-1:0] right_value,
   output logic signed [isu_pkg::VALUE_WIDTH-1:0]      value,
   output logic                                        match
);
   import isu_pkg::*;

   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] value_in;
   logic [CMP_WIDTH:0]            index_up;

   assign index_up = {1'b0, cell_index} + {{CMP_WIDTH{1'b0}}, 1'b1};

   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (cell_index == cmd.pos) begin
               value_in = cmd.key;
            end else if (cell_index > cmd.pos && cell_index <= cmd.count) begin
               value_in = left_value;
            end
         end
         CELL_REMOVE: begin
            if (cell_index >= cmd.pos && index_up < {1'b0, cmd.count}) begin
               value_in = right_value;
            end
         end
         CELL_ROTATE: begin
            if (cell_index < cmd.count) begin
               value_in = left_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign match = (cell_index < cmd.count) && (value_ff == cmd.key);

endmodule

`default_nettype wire

@@ rtl/indexed_sequence_store_unit.sv @@
// Top level of the indexed sequence store: request decode, cell chain, rotate sequencer,
// response register. Depends on isu_pkg and isu_cell.
//
// channel | dir | handshake             | tdata fields (low bit up)
// req     | in  | req_tvalid/req_tready | mode, position, item_value, shift_amount
// rsp     | out | rsp_tvalid/rsp_tready | status, out_value, found_position, count
//
// Insert, remove, read, find, clear and unused modes: completed on acceptance, with a registered response.
// Rotate: the chain moves one place per cycle, shift_amount places (none on an empty store), then responds.
// Reset empties the store; cell contents are not cleared.
// A response waiting on rsp_tready blocks new requests only until it is taken.
`default_nettype none

module indexed_sequence_store_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // mode[2:0], position[7:3], item_value[39:8], shift_amount[44:40], zero fill
   input  wire logic [isu_pkg::REQ_WIDTH-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // status[1:0], out_value[33:2], found_position[37:34], count[42:38], zero fill
   output logic [isu_pkg::RSP_WIDTH-1:0]      rsp_tdata
);
   import isu_pkg::*;

   logic [MODE_WIDTH-1:0]         req_mode;
   logic [POS_WIDTH-1:0]          req_position;
   logic signed [VALUE_WIDTH-1:0] req_item_value;
   logic [SHIFT_WIDTH-1:0]        req_shift_amount;

   state_type               state_ff, state_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [SHIFT_WIDTH-1:0]  remain_ff, remain_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_WIDTH-1:0]    rsp_data_ff, rsp_data_in;

   cell_cmd_type            cmd;
   logic signed [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]        cell_match;

   logic                    out_free;
   logic                    accept;
   logic [CMP_WIDTH-1:0]    pos_ext;
   logic [CMP_WIDTH-1:0]    count_ext;
   logic [CMP_WIDTH-1:0]    last_index;
   logic signed [VALUE_WIDTH-1:0] read_value;
   logic signed [VALUE_WIDTH-1:0] wrap_value;
   logic                    found;
   logic [INDEX_WIDTH-1:0]  found_index;

   status_type              rsp_status;
   logic signed [VALUE_WIDTH-1:0] rsp_value;
   logic [FOUND_WIDTH-1:0]  rsp_found;
   logic                    rsp_load;

   assign req_mode         = req_tdata[MODE_WIDTH-1:0];
   assign req_position     = req_tdata[MODE_WIDTH +: POS_WIDTH];
   assign req_item_value   = req_tdata[MODE_WIDTH+POS_WIDTH +: VALUE_WIDTH];
   assign req_shift_amount = req_tdata[MODE_WIDTH+POS_WIDTH+VALUE_WIDTH +: SHIFT_WIDTH];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   assign pos_ext    = CMP_WIDTH'(req_position);
   assign count_ext  = CMP_WIDTH'(count_ff);
   assign last_index = count_ext - {{(CMP_WIDTH-1){1'b0}}, 1'b1};
   assign read_value = cell_value[pos_ext[INDEX_WIDTH-1:0]];
   assign wrap_value = cell_value[last_index[INDEX_WIDTH-1:0]];

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic signed [VALUE_WIDTH-1:0] left_v;
         logic signed [VALUE_WIDTH-1:0] right_v;
         if (g == 0) begin : g_first
            assign left_v = wrap_value;
         end else begin : g_inner_l
            assign left_v = cell_value[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign right_v = cell_value[g];
         end else begin : g_inner_r
            assign right_v = cell_value[g+1];
         end
         isu_cell u_cell (
            .clock       (clock),
            .cell_index  (CMP_WIDTH'(g)),
            .cmd         (cmd),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[g]),
            .match       (cell_match[g])
         );
      end
   endgenerate

   always_comb begin
      found       = 1'b0;
      found_index = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (cell_match[i]) begin
            found       = 1'b1;
            found_index = INDEX_WIDTH'(i);
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      remain_in  = remain_ff;
      rsp_load   = 1'b0;
      rsp_status = STATUS_OK;
      rsp_value  = '0;
      rsp_found  = '0;
      cmd.op     = CELL_HOLD;
      cmd.pos    = pos_ext;
      cmd.count  = count_ext;
      cmd.key    = req_item_value;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               case (req_mode)
                  MODE_INSERT: begin
                     if (count_ff == COUNT_WIDTH'(DEPTH)) begin
                        rsp_status = STATUS_FULL;
                     end else if (pos_ext > count_ext) begin
                        rsp_status = STATUS_RANGE;
                     end else begin
                        cmd.op   = CELL_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  MODE_REMOVE: begin
                     if (pos_ext >= count_ext) begin
                        rsp_status = STATUS_RANGE;
                     end else begin
                        rsp_value = read_value;
                        cmd.op    = CELL_REMOVE;
                        count_in  = count_ff - 1'b1;
                     end
                  end
                  MODE_READ: begin
                     if (pos_ext >= count_ext) begin
                        rsp_status = STATUS_RANGE;
                     end else begin
                        rsp_value = read_value;
                     end
                  end
                  MODE_FIND: begin
                     if (found) begin
                        rsp_found = FOUND_WIDTH'(found_index);
                     end else begin
                        rsp_status = STATUS_NONE;
                     end
                  end
                  MODE_ROTATE: begin
                     rsp_load  = 1'b0;
                     state_in  = ST_ROTATE;
                     remain_in = (count_ff == '0) ? '0 : req_shift_amount;
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                  end
                  default: rsp_status = STATUS_OK;
               endcase
            end
         end
         ST_ROTATE: begin
            if (remain_ff != '0) begin
               cmd.op    = CELL_ROTATE;
               remain_in = remain_ff - 1'b1;
            end else if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_data_in = RSP_WIDTH'({COUNT_OUT_WIDTH'(count_in), rsp_found, rsp_value, rsp_status});
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("fill count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_INSERT && count_ff != COUNT_WIDTH'(DEPTH)
       && pos_ext <= count_ext) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the store");

   a_rotate_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE) |=> count_ff == $past(count_ff))
      else $error("count changed during rotate");

   a_rotate_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE && remain_ff != '0) |=> !rsp_valid_ff || $past(rsp_valid_ff))
      else $error("response issued before rotate finished");

endmodule

`default_nettype wire
